FILE: hdl/pcr_pkg.sv
// shared types and constants for the priority claim resolver
`default_nettype none
package pcr_pkg;

   localparam int DefaultNumSlots = 8;

   localparam logic [1:0] CMD_CLAIM   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_SESSION = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_ACTIVE   = 2'd1;
   localparam logic [1:0] ST_DISABLED = 2'd2;
   localparam logic [1:0] ST_RESERVED = 2'd3;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ENABLE  = 2'd1;
   localparam logic [1:0] ACT_SLEEP   = 2'd2;
   localparam logic [1:0] ACT_DISABLE = 2'd3;

   localparam logic [1:0] REG_MAX_CUR = 2'd0;
   localparam logic [1:0] REG_MIN_CUR = 2'd1;
   localparam logic [1:0] REG_SLEEP   = 2'd2;

   localparam logic [7:0]  NONE8  = 8'hFF;
   localparam logic [31:0] NONE32 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] client_id;
      logic [15:0] priority_req;
      logic [1:0]  req_state;
      logic [7:0]  req_charge_current;
      logic [7:0]  req_max_current;
      logic [31:0] req_energy_limit;
      logic [31:0] req_time_limit;
      logic        req_auto_release;
   } req_word_type;

   typedef struct packed {
      logic        accepted;
      logic        has_claims;
      logic [1:0]  target_state;
      logic [1:0]  drive_action;
      logic [7:0]  pilot_current;
      logic        pilot_changed;
      logic [7:0]  target_charge_current;
      logic [7:0]  target_max_current;
      logic [31:0] target_energy_limit;
      logic [31:0] target_time_limit;
      logic [7:0]  table_version;
   } rsp_word_type;

   // one stored claim
   typedef struct packed {
      logic [15:0] client;
      logic [15:0] prio;
      logic [1:0]  state;
      logic [7:0]  charge;
      logic [7:0]  maxc;
      logic [31:0] energy;
      logic [31:0] tlim;
      logic        auto_rel;
   } slot_type;

   // running winners of the resolve pass
   typedef struct packed {
      logic        any;
      logic [15:0] p_st;
      logic [15:0] p_ch;
      logic [15:0] p_mx;
      logic [15:0] p_en;
      logic [15:0] p_tm;
      logic [1:0]  t_state;
      logic [7:0]  t_ch;
      logic [7:0]  t_mx;
      logic [31:0] t_en;
      logic [31:0] t_tm;
   } resolve_type;

endpackage
`default_nettype wire

FILE: hdl/priority_claim_resolver.sv
// top level: claim table, command sequencer and resolve pass
// a command runs through these steps from accepted request word to valid response word
// (a search sweep over the slots, an update state, a resolve sweep, a finish state)
// commands are handled one at a time
// req_stall stays high while a command runs and until its response word is taken
// synchronous active-high reset frees all slots, sets state active, clears pilot and version
`default_nettype none
module priority_claim_resolver #(
   parameter int NUM_SLOTS = pcr_pkg::DefaultNumSlots
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire pcr_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output pcr_pkg::rsp_word_type     rsp_word,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [1:0]                 csr_index,
   input  wire [7:0]                 csr_data
);
   import pcr_pkg::*;

   localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CntW = $clog2(NUM_SLOTS + 1);
   localparam logic [CntW-1:0] LastSlot = CntW'(NUM_SLOTS - 1);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SEARCH  = 5'b00010,
      S_UPDATE  = 5'b00100,
      S_RESOLVE = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   slot_type     slots_ff [NUM_SLOTS];
   logic [CntW-1:0] cnt_ff, cnt_in;
   req_word_type cmd_ff;
   logic [1:0]   cmd_state;
   logic         found_ff, found_in, free_ok_ff, free_ok_in;
   logic [IdxW-1:0] pick_ff, pick_in, free_ff, free_in;
   logic         acc_ff, acc_in;
   resolve_type  res_ff, res_in, res_step;
   logic [7:0]   max_cur_ff, min_cur_ff;
   logic         sleep_ff;
   logic [1:0]   cmd_st_ff;
   logic [7:0]   last_pilot_ff, version_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;
   slot_type     cur_slot, new_slot;
   logic [IdxW-1:0] cur_idx, tgt_idx;
   logic [7:0]   pilot;
   logic [1:0]   action;

   assign cur_idx   = cnt_ff[IdxW-1:0];
   assign cur_slot  = slots_ff[cur_idx];
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign cmd_state = (cmd_ff.req_state == ST_RESERVED) ? ST_NONE : cmd_ff.req_state;
   assign tgt_idx   = found_ff ? pick_ff : free_ff;

   // claim as it would be stored
   always_comb begin
      new_slot.client   = cmd_ff.client_id;
      new_slot.prio     = cmd_ff.priority_req;
      new_slot.state    = cmd_state;
      new_slot.charge   = cmd_ff.req_charge_current;
      new_slot.maxc     = cmd_ff.req_max_current;
      new_slot.energy   = cmd_ff.req_energy_limit;
      new_slot.tlim     = cmd_ff.req_time_limit;
      new_slot.auto_rel = cmd_ff.req_auto_release;
   end

   pcr_resolve_unit u_resolve (
      .slot   (cur_slot),
      .acc    (res_ff),
      .result (res_step)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      found_in   = found_ff;
      pick_in    = pick_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in   = S_SEARCH;
               cnt_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
            end
         end
         S_SEARCH: begin
            if (!found_ff && cur_slot.client == cmd_ff.client_id) begin
               found_in = 1'b1;
               pick_in  = cur_idx;
            end
            if (!free_ok_ff && cur_slot.client == 16'd0) begin
               free_ok_in = 1'b1;
               free_in    = cur_idx;
            end
            if (cnt_ff == LastSlot) state_in = S_UPDATE;
            else cnt_in = cnt_ff + 1'b1;
         end
         S_UPDATE: begin
            acc_in = 1'b0;
            if (cmd_ff.client_id != 16'd0) begin
               if (cmd_ff.cmd == CMD_CLAIM) acc_in = found_ff || free_ok_ff;
               else if (cmd_ff.cmd == CMD_RELEASE) acc_in = found_ff;
            end
            res_in = '{any: 1'b0, p_st: '0, p_ch: '0, p_mx: '0, p_en: '0, p_tm: '0,
                       t_state: ST_ACTIVE, t_ch: NONE8, t_mx: NONE8,
                       t_en: NONE32, t_tm: NONE32};
            cnt_in   = '0;
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            res_in = res_step;
            if (cnt_ff == LastSlot) state_in = S_FINISH;
            else cnt_in = cnt_ff + 1'b1;
         end
         S_FINISH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // pilot and drive action from the finished pass
   always_comb begin
      pilot = max_cur_ff;
      if (res_ff.t_mx != NONE8 && res_ff.t_mx < pilot) pilot = res_ff.t_mx;
      if (res_ff.t_ch != NONE8 && res_ff.t_ch < pilot) pilot = res_ff.t_ch;
      if (pilot < min_cur_ff) pilot = min_cur_ff;
      action = ACT_NONE;
      if (res_ff.t_state != cmd_st_ff) begin
         if (res_ff.t_state == ST_ACTIVE) action = ACT_ENABLE;
         else action = sleep_ff ? ACT_SLEEP : ACT_DISABLE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_cur_ff    <= 8'd32;
         min_cur_ff    <= 8'd6;
         sleep_ff      <= 1'b1;
         cmd_st_ff     <= ST_ACTIVE;
         last_pilot_ff <= '0;
         version_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MAX_CUR: max_cur_ff <= csr_data;
               REG_MIN_CUR: min_cur_ff <= csr_data;
               REG_SLEEP:   sleep_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (state_ff == S_UPDATE && cmd_ff.client_id != 16'd0) begin
            if (cmd_ff.cmd == CMD_CLAIM && (found_ff || free_ok_ff) &&
                slots_ff[tgt_idx] != new_slot)
               version_ff <= version_ff + 8'd1;
            else if (cmd_ff.cmd == CMD_RELEASE && found_ff)
               version_ff <= version_ff + 8'd1;
         end
         if (state_ff == S_FINISH) begin
            rsp_valid_ff  <= 1'b1;
            last_pilot_ff <= pilot;
            cmd_st_ff     <= res_ff.t_state;
         end
      end
   end

   // slot table, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slots_ff[i] <= '{client: '0, prio: '0, state: ST_NONE, charge: NONE8,
                             maxc: NONE8, energy: NONE32, tlim: NONE32, auto_rel: 1'b0};
         end
      end else if (state_ff == S_UPDATE) begin
         if (cmd_ff.cmd == CMD_CLAIM) begin
            if (cmd_ff.client_id != 16'd0 && (found_ff || free_ok_ff))
               slots_ff[tgt_idx] <= new_slot;
         end else if (cmd_ff.cmd == CMD_RELEASE) begin
            if (cmd_ff.client_id != 16'd0 && found_ff)
               slots_ff[pick_ff].client <= '0;
         end else if (cmd_ff.cmd == CMD_SESSION) begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slots_ff[i].auto_rel) slots_ff[i].client <= '0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      found_ff   <= found_in;
      pick_ff    <= pick_in;
      free_ok_ff <= free_ok_in;
      free_ff    <= free_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
      if (state_ff == S_IDLE && req_valid && !req_stall) cmd_ff <= req_word;
      if (state_ff == S_FINISH) begin
         rsp_ff.accepted              <= acc_ff;
         rsp_ff.has_claims            <= res_ff.any;
         rsp_ff.target_state          <= res_ff.t_state;
         rsp_ff.drive_action          <= action;
         rsp_ff.pilot_current         <= pilot;
         rsp_ff.pilot_changed         <= (pilot != last_pilot_ff);
         rsp_ff.target_charge_current <= res_ff.t_ch;
         rsp_ff.target_max_current    <= res_ff.t_mx;
         rsp_ff.target_energy_limit   <= res_ff.t_en;
         rsp_ff.target_time_limit     <= res_ff.t_tm;
         rsp_ff.table_version         <= version_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_finish_gives_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> rsp_valid)
      else $error("finish without response word");
   a_state_resolved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.target_state == ST_ACTIVE ||
                     rsp_word.target_state == ST_DISABLED))
      else $error("bad target state");
   a_pilot_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (pilot >= min_cur_ff))
      else $error("pilot below minimum");
`endif

endmodule
`default_nettype wire

FILE: hdl/pcr_resolve_unit.sv
// shared per-slot compare unit: folds one slot into the running winners
`default_nettype none
module pcr_resolve_unit (
   input  wire pcr_pkg::slot_type    slot,
   input  wire pcr_pkg::resolve_type acc,
   output pcr_pkg::resolve_type      result
);
   import pcr_pkg::*;

   always_comb begin
      result = acc;
      if (slot.client != 16'd0) begin
         result.any = 1'b1;
         if (slot.prio > acc.p_st && slot.state != ST_NONE) begin
            result.t_state = slot.state;
            result.p_st    = slot.prio;
         end
         if (slot.prio > acc.p_ch && slot.charge != NONE8) begin
            result.t_ch = slot.charge;
            result.p_ch = slot.prio;
         end
         if (slot.prio > acc.p_mx && slot.maxc != NONE8) begin
            result.t_mx = slot.maxc;
            result.p_mx = slot.prio;
         end
         if (slot.prio > acc.p_en && slot.energy != NONE32) begin
            result.t_en = slot.energy;
            result.p_en = slot.prio;
         end
         if (slot.prio > acc.p_tm && slot.tlim != NONE32) begin
            result.t_tm = slot.tlim;
            result.p_tm = slot.prio;
         end
      end
   end

endmodule
`default_nettype wire
